/* src/rats_pkg.sv */
// package for the repeating alarm table scheduler
// holds payload structs, opcode and status codes, mode codes and period helper
package rats_pkg;

   localparam int ALARM_ENTRIES = 8;
   localparam int IDX_W = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;

   localparam logic [31:0] SECS_HOUR = 32'd3600;
   localparam logic [31:0] SECS_DAY  = 32'd86400;
   localparam logic [31:0] SECS_WEEK = 32'd604800;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_SET     = 2'd1,
      OP_ENABLE  = 2'd2,
      OP_DISABLE = 2'd3
   } opcode_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_BAD_WIN   = 2'd2;

   localparam logic [3:0] MODE_EMPTY    = 4'd0;
   localparam logic [3:0] MODE_ONCE     = 4'd1;
   localparam logic [3:0] MODE_HOUR     = 4'd2;
   localparam logic [3:0] MODE_DAY      = 4'd3;
   localparam logic [3:0] MODE_WEEK     = 4'd4;
   localparam logic [3:0] MODE_IV_SEC   = 4'd7;
   localparam logic [3:0] MODE_IV_MIN   = 4'd8;
   localparam logic [3:0] MODE_IV_HOUR  = 4'd9;
   localparam logic [3:0] MODE_IV_DAY   = 4'd10;
   localparam logic [3:0] MODE_WEEKDAYS = 4'd11;

   localparam logic [1:0] CSR_GLOBAL_ENABLE = 2'd0;
   localparam logic [1:0] CSR_EXPIRE        = 2'd1;
   localparam logic [1:0] CSR_TICK_SECS     = 2'd2;
   localparam logic [1:0] CSR_RESYNC        = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        net_time_valid;
      logic [31:0] net_time;
      logic [3:0]  alarm_index;
      logic [31:0] start_time;
      logic [31:0] stop_time;
      logic [3:0]  repeat_mode;
      logic        alarm_enabled;
      logic [15:0] repeat_interval;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        relay_update;
      logic        relay_on;
      logic [31:0] current_time;
      logic        save_request;
   } rsp_type;

   // divider control between sequencer and divider
   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [47:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
      logic [47:0] remainder;
   } div_sts_type;

   // multiplier factor of a mode, used with the interval: period = factor * interval
   function automatic logic [16:0] mode_factor(input logic [3:0] m);
      case (m)
         MODE_IV_SEC:  mode_factor = 17'd1;
         MODE_IV_MIN:  mode_factor = 17'd60;
         MODE_IV_HOUR: mode_factor = 17'd3600;
         MODE_IV_DAY:  mode_factor = 17'd86400;
         default:      mode_factor = 17'd0;
      endcase
   endfunction

   // exact period, at most 65535*86400 which fits in 33 bits
   function automatic logic [32:0] mode_period(input logic [3:0] m, input logic [15:0] iv);
      logic [32:0] p;
      p = '0;
      case (m)
         MODE_HOUR: p = {1'b0, SECS_HOUR};
         MODE_DAY:  p = {1'b0, SECS_DAY};
         MODE_WEEK: p = {1'b0, SECS_WEEK};
         MODE_IV_SEC, MODE_IV_MIN, MODE_IV_HOUR, MODE_IV_DAY:
            p = 33'(mode_factor(m) * {17'd0, iv});
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

/* src/rats_div.sv */
// restoring divider, one quotient bit per cycle
// depends on rats_pkg
module rats_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rats_pkg::div_cmd_type cmd,
   output rats_pkg::div_sts_type sts
);
   import rats_pkg::*;

   logic [47:0] quo_ff, quo_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] trial;

   // one shift-subtract step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[47]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[48]) begin
            rem_in = trial[47:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[46:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff;
   assign sts.remainder = rem_ff;
endmodule

/* src/repeating_alarm_table_scheduler.sv */
// Repeating alarm table scheduler.
// Channels: req (valid/ready, req_type payload) carries ticks and commands, rsp
// (valid/ready, rsp_type payload) returns exactly one result per request. The
// csr write port sets global enable, expire window, tick length and resync period.
// A tick walks the table one entry per cycle; when time is unknown or relay
// driving is off, it goes straight to the result without a walk.
// When the resync period was lowered to or below the running count, that tick
// first reduces the count on the shared divider.
// A set that needs catch-up runs the shared 48-bit restoring divider, one
// quotient bit a cycle, plus one multiply stage. One item is worked on at a
// time; req_ready is low while an item is in work or its result is not taken.
// The result sits in an output register; while the receiver stalls it is held
// and no new request is taken.
// Reset (synchronous, active high) empties the table, zeroes time and the
// resync counter and loads register defaults; no clearing pass is needed.
// A zero local time means the time is not known; relay is not driven then.
module repeating_alarm_table_scheduler (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rats_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rats_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import rats_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MODWAIT, S_WALK, S_SETCHK, S_DIVWAIT, S_MUL, S_STORE, S_RESP
   } state_type;

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] wstart_ff [ALARM_ENTRIES];
   logic [31:0] wstop_ff  [ALARM_ENTRIES];
   logic [3:0]  mode_ff   [ALARM_ENTRIES];
   logic [ALARM_ENTRIES-1:0] en_ff, en_in;
   logic [15:0] iv_ff     [ALARM_ENTRIES];

   logic [31:0] time_ff, time_in;
   logic [15:0] resync_ff, resync_in;
   logic        genable_ff;
   logic [15:0] expire_ff;
   logic [7:0]  ticks_ff;
   logic [15:0] period_ff;

   logic [IDX_W:0] walk_ff, walk_in;
   logic        run_ff, run_in;
   logic        save_ff, save_in;
   logic [31:0] add_ff, add_in;
   logic [32:0] per_ff, per_in;

   // entry write port
   logic        wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0] wr_start, wr_stop;
   logic        wr_full;

   div_cmd_type div_cmd;
   div_sts_type div_sts;

   rats_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .sts(div_sts));

   logic [IDX_W-1:0] wi;
   logic [IDX_W-1:0] ci;
   logic        idx_ok;
   logic        nvalid, due;
   logic [31:0] t, e_start, e_stop, p32;
   logic [32:0] p33;
   logic [3:0]  e_mode;
   logic [32:0] stop_exp;
   logic [16:0] cnt_next;

   assign wi     = walk_ff[IDX_W-1:0];
   assign ci     = req_ff.alarm_index[IDX_W-1:0];
   assign idx_ok = {28'd0, req_ff.alarm_index} < ALARM_ENTRIES;
   assign t       = time_ff;
   assign e_start = wstart_ff[wi];
   assign e_stop  = wstop_ff[wi];
   assign e_mode  = mode_ff[wi];
   assign stop_exp = {1'b0, e_stop} + {17'd0, expire_ff};
   assign p33      = mode_period(e_mode, iv_ff[wi]);
   assign p32      = p33[31:0];
   assign nvalid  = req_data.net_time_valid && (req_data.net_time != 32'd0);
   assign due     = (resync_ff == 16'd0) || (time_ff == 32'd0);
   assign cnt_next = {1'b0, resync_ff} + 17'd1;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      en_in     = en_ff;
      time_in   = time_ff;
      resync_in = resync_ff;
      walk_in   = walk_ff;
      run_in    = run_ff;
      save_in   = save_ff;
      add_in    = add_ff;
      per_in    = per_ff;
      wr_en     = 1'b0;
      wr_full   = 1'b0;
      wr_idx    = wi;
      wr_start  = e_start + p32;
      wr_stop   = e_stop + p32;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = {16'd0, time_ff} - {16'd0, req_ff.stop_time} + 48'd1;
      div_cmd.divisor  = {15'd0, per_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               run_in = 1'b0;
               save_in = 1'b0;
               walk_in = '0;
               unique case (opcode_type'(req_data.opcode))
                  OP_TICK: begin
                     if (due && nvalid) time_in = req_data.net_time;
                     else if ({16'd0, time_ff} > {15'd0, period_ff, 1'b0})
                        time_in = time_ff + {24'd0, ticks_ff};
                     add_in = '0;
                     state_in = S_WALK;
                     if (period_ff == 16'd0) resync_in = '0;
                     else if (cnt_next == {1'b0, period_ff}) resync_in = '0;
                     else if (cnt_next < {1'b0, period_ff}) resync_in = cnt_next[15:0];
                     else state_in = S_MODWAIT;
                  end
                  OP_SET: state_in = S_SETCHK;
                  default: begin
                     if ({28'd0, req_data.alarm_index} >= ALARM_ENTRIES)
                        rsp_in.status = ST_BAD_INDEX;
                     else begin
                        en_in[req_data.alarm_index[IDX_W-1:0]] =
                           (opcode_type'(req_data.opcode) == OP_ENABLE);
                        rsp_in.save_request = 1'b1;
                     end
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_MODWAIT: begin
            // count past a lowered period: remainder on the shared divider
            div_cmd.dividend = {31'd0, cnt_next};
            div_cmd.divisor  = {32'd0, period_ff};
            if (add_ff == 32'd0 && !div_sts.done) begin
               div_cmd.start = 1'b1;
               add_in = 32'd1;
            end
            if (div_sts.done) begin
               resync_in = div_sts.remainder[15:0];
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (time_ff == 32'd0 || !genable_ff) begin
               state_in = S_RESP;
            end else if (walk_ff == (IDX_W+1)'(ALARM_ENTRIES)) begin
               rsp_in.relay_update = 1'b1;
               rsp_in.relay_on = run_ff;
               state_in = S_RESP;
            end else begin
               if (en_ff[wi] && e_mode != MODE_EMPTY && e_mode <= MODE_WEEKDAYS) begin
                  if (t >= e_start && t < e_stop) run_in = 1'b1;
                  else if (e_mode == MODE_ONCE) begin
                     if (t >= e_stop && {1'b0, t} <= stop_exp) begin
                        en_in[wi] = 1'b0;
                        save_in = 1'b1;
                     end
                  end else if (t >= e_stop) begin
                     wr_en = 1'b1;
                     save_in = 1'b1;
                  end
               end
               walk_in = walk_ff + 1'b1;
            end
            rsp_in.save_request = save_in;
         end
         S_SETCHK: begin
            per_in = mode_period(req_ff.repeat_mode, req_ff.repeat_interval);
            add_in = '0;
            if (!idx_ok) begin
               rsp_in.status = ST_BAD_INDEX;
               state_in = S_RESP;
            end else if (req_ff.start_time >= req_ff.stop_time ||
                         (req_ff.repeat_mode >= MODE_IV_SEC &&
                          req_ff.repeat_mode <= MODE_IV_DAY &&
                          req_ff.repeat_interval == 16'd0)) begin
               rsp_in.status = ST_BAD_WIN;
               state_in = S_RESP;
            end else if (time_ff != 32'd0 && req_ff.stop_time < time_ff &&
                         per_in != 33'd0) begin
               state_in = S_DIVWAIT;
            end else begin
               state_in = S_STORE;
            end
         end
         S_DIVWAIT: begin
            // first cycle here launches the divider (per_ff now valid)
            if (add_ff == 32'd0 && !div_sts.done) begin
               div_cmd.start = 1'b1;
               add_in = 32'd1;
            end
            if (div_sts.done) state_in = S_MUL;
         end
         S_MUL: begin
            // only the low 32 bits of (q+1)*p matter
            add_in = 32'(div_sts.quotient[31:0] + 32'd1) * per_ff[31:0];
            state_in = S_STORE;
         end
         S_STORE: begin
            wr_en    = 1'b1;
            wr_full  = 1'b1;
            wr_idx   = ci;
            wr_start = req_ff.start_time + (state_ff == S_STORE && per_ff != 0 &&
                        time_ff != 0 && req_ff.stop_time < time_ff ? add_ff : 32'd0);
            wr_stop  = req_ff.stop_time + (per_ff != 0 &&
                        time_ff != 0 && req_ff.stop_time < time_ff ? add_ff : 32'd0);
            en_in[ci] = req_ff.alarm_enabled;
            rsp_in.save_request = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_in.current_time = time_ff;
            if (rsp_ready && rsp_valid) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   always_comb begin
      rsp_data = rsp_ff;
      rsp_data.current_time = time_ff;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         en_ff      <= '0;
         time_ff    <= '0;
         resync_ff  <= '0;
         genable_ff <= 1'b1;
         expire_ff  <= 16'd60;
         ticks_ff   <= 8'd1;
         period_ff  <= 16'd60;
         walk_ff    <= '0;
         for (int i = 0; i < ALARM_ENTRIES; i++) mode_ff[i] <= MODE_EMPTY;
      end else begin
         state_ff  <= state_in;
         en_ff     <= en_in;
         time_ff   <= time_in;
         resync_ff <= resync_in;
         walk_ff   <= walk_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_GLOBAL_ENABLE: genable_ff <= csr_data[0];
               CSR_EXPIRE:        expire_ff  <= csr_data;
               CSR_TICK_SECS:     ticks_ff   <= csr_data[7:0];
               CSR_RESYNC:        period_ff  <= csr_data;
               default: ;
            endcase
         end
         if (wr_en && wr_full) mode_ff[wr_idx] <= req_ff.repeat_mode;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      run_ff  <= run_in;
      save_ff <= save_in;
      add_ff  <= add_in;
      per_ff  <= per_in;
      if (wr_en) begin
         wstart_ff[wr_idx] <= wr_start;
         wstop_ff[wr_idx]  <= wr_stop;
         if (wr_full) iv_ff[wr_idx] <= req_ff.repeat_interval;
      end
   end

   // a result is never presented while a new request could be taken
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("ready and result valid together");
   // a taken request leads to work, never straight to idle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");
   // an out of range index never asks for a save
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_BAD_INDEX) |-> !rsp_data.save_request)
      else $error("save on bad index");
endmodule
